// ===== hw/rtl/ptsch_pkg.sv =====
// shared types, opcodes and defaults for the periodic task scheduler
package ptsch_pkg;

    localparam int TASK_SLOTS_DEF = 16;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_CREATE   = 3'd1;
    localparam logic [2:0] OP_WAKE     = 3'd2;
    localparam logic [2:0] OP_SLEEP    = 3'd3;
    localparam logic [2:0] OP_DISPATCH = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  task_index;
        logic [15:0] period_ticks;
    } cmd_t;

    typedef struct packed {
        logic       served_valid;
        logic [3:0] served_index;
        logic       create_rejected;
    } rsp_t;

endpackage

// ===== hw/rtl/periodic_task_scheduler.sv =====
// periodic task scheduler top level: slot table, tick sweep and round-robin dispatch
//
//  channel   | signals           | handshake
//  ----------+-------------------+------------------------------------------
//  command   | start, busy, cmd  | transfer when start high and busy low
//  response  | done, rsp         | one cycle strobe, always taken
//
// create, wake, sleep and unknown opcodes: response in the cycle after the transfer
// tick: busy while the sweep runs, one slot per cycle through the counter memory port
// dispatch: busy until a ready slot is served or every slot is examined, one slot examined per cycle
// reset clears used and ready bits at once; the period and counter memories need no clearing
// responses cannot be held off, so nothing inside ever waits on the receiver
module periodic_task_scheduler #(
    parameter int TASK_SLOTS = ptsch_pkg::TASK_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ptsch_pkg::cmd_t cmd,
    output logic            done,
    output ptsch_pkg::rsp_t rsp
);
    import ptsch_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN
    } state_t;

    state_t                  state_reg, state_next;
    logic [TASK_SLOTS-1:0]   used_reg, used_next;
    logic [TASK_SLOTS-1:0]   ready_reg, ready_next;
    logic [IDX_W-1:0]        scan_pos_reg, scan_pos_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    logic                    upd_vld_reg, upd_vld_next;
    logic [IDX_W-1:0]        upd_idx_reg, upd_idx_next;
    logic                    done_reg, done_next;
    rsp_t                    rsp_reg, rsp_next;

    logic [15:0]             period_mem [TASK_SLOTS];
    logic [15:0]             count_mem  [TASK_SLOTS];
    logic [15:0]             period_rd_reg;
    logic [15:0]             count_rd_reg;

    logic                    per_we;
    logic [IDX_W-1:0]        per_wa;
    logic [15:0]             per_wd;
    logic                    cnt_we;
    logic [IDX_W-1:0]        cnt_wa;
    logic [15:0]             cnt_wd;
    logic [IDX_W-1:0]        rd_addr;

    logic                    accept;
    logic                    in_range;
    logic [IDX_W-1:0]        cmd_idx;
    logic [15:0]             cnt_inc;
    logic                    expire;
    logic [IDX_W-1:0]        pos_inc;
    logic                    hit;

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign rsp      = rsp_reg;
    assign accept   = start && !busy;
    assign in_range = int'(cmd.task_index) < TASK_SLOTS;
    assign cmd_idx  = IDX_W'(cmd.task_index);
    assign rd_addr  = ptr_reg[IDX_W-1:0];
    assign cnt_inc  = count_rd_reg + 16'd1;
    assign expire   = (cnt_inc >= period_rd_reg);
    assign pos_inc  = (pos_reg == IDX_W'(TASK_SLOTS - 1)) ? '0 : pos_reg + IDX_W'(1);
    assign hit      = used_reg[pos_reg] && ready_reg[pos_reg];

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        ready_next    = ready_reg;
        scan_pos_next = scan_pos_reg;
        pos_next      = pos_reg;
        n_next        = n_reg;
        ptr_next      = ptr_reg;
        upd_vld_next  = 1'b0;
        upd_idx_next  = upd_idx_reg;
        done_next     = 1'b0;
        rsp_next      = '0;
        per_we        = 1'b0;
        per_wa        = cmd_idx;
        per_wd        = cmd.period_ticks;
        cnt_we        = 1'b0;
        cnt_wa        = cmd_idx;
        cnt_wd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.opcode)
                        OP_TICK:
                        begin
                            state_next = ST_TICK;
                            ptr_next   = '0;
                        end
                        OP_CREATE:
                        begin
                            done_next = 1'b1;
                            if (in_range)
                            begin
                                if (used_reg[cmd_idx])
                                begin
                                    rsp_next.create_rejected = 1'b1;
                                end
                                else
                                begin
                                    used_next[cmd_idx]  = 1'b1;
                                    ready_next[cmd_idx] = 1'b0;
                                    per_we              = 1'b1;
                                    cnt_we              = 1'b1;
                                end
                            end
                        end
                        OP_WAKE:
                        begin
                            done_next = 1'b1;
                            if (in_range)
                            begin
                                ready_next[cmd_idx] = 1'b1;
                            end
                        end
                        OP_SLEEP:
                        begin
                            done_next = 1'b1;
                            if (in_range)
                            begin
                                ready_next[cmd_idx] = 1'b0;
                            end
                        end
                        OP_DISPATCH:
                        begin
                            state_next = ST_SCAN;
                            pos_next   = scan_pos_reg;
                            n_next     = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                // read slot ptr while updating the slot read the cycle before
                if (ptr_reg < CNT_W'(TASK_SLOTS))
                begin
                    upd_vld_next = 1'b1;
                    upd_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
                if (upd_vld_reg && used_reg[upd_idx_reg])
                begin
                    cnt_we = 1'b1;
                    cnt_wa = upd_idx_reg;
                    cnt_wd = expire ? 16'd0 : cnt_inc;
                    if (expire)
                    begin
                        ready_next[upd_idx_reg] = 1'b1;
                    end
                end
                if (upd_vld_reg && (ptr_reg == CNT_W'(TASK_SLOTS)))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    ready_next[pos_reg]   = 1'b0;
                    rsp_next.served_valid = 1'b1;
                    rsp_next.served_index = 4'(pos_reg);
                    scan_pos_next         = pos_inc;
                    state_next            = ST_IDLE;
                    done_next             = 1'b1;
                end
                else if (n_reg == CNT_W'(TASK_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc;
                    n_next   = n_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            ready_reg    <= '0;
            scan_pos_reg <= '0;
            pos_reg      <= '0;
            n_reg        <= '0;
            ptr_reg      <= '0;
            upd_vld_reg  <= 1'b0;
            upd_idx_reg  <= '0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            ready_reg    <= ready_next;
            scan_pos_reg <= scan_pos_next;
            pos_reg      <= pos_next;
            n_reg        <= n_next;
            ptr_reg      <= ptr_next;
            upd_vld_reg  <= upd_vld_next;
            upd_idx_reg  <= upd_idx_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
        end
    end

    // period and counter memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[per_wa] <= per_wd;
        end
        if (cnt_we)
        begin
            count_mem[cnt_wa] <= cnt_wd;
        end
        period_rd_reg <= period_mem[rd_addr];
        count_rd_reg  <= count_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/ptsch_checker.sv =====
// port-level checks for the periodic task scheduler, bound to the top level
module ptsch_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input ptsch_pkg::cmd_t cmd,
    input logic            done,
    input ptsch_pkg::rsp_t rsp
);
    import ptsch_pkg::*;

    // a response never overlaps a command still in progress
    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response strobe while busy");

    // every response follows a transfer or a busy period
    a_done_cause : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("response with no command behind it");

    // busy only starts on a transfer
    a_busy_rise : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // a rejected create answers the create transferred just before
    a_reject_src : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.create_rejected) |->
            $past(start && !busy && (cmd.opcode == OP_CREATE)))
        else $error("rejection not caused by a create");

    // a served task and a rejection never share one response
    a_reject_excl : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.create_rejected) |-> !rsp.served_valid)
        else $error("served and rejected in one response");

endmodule

bind periodic_task_scheduler ptsch_checker u_ptsch_checker (.*);

// ===== tb/tb_periodic_task_scheduler.sv =====
`timescale 1ns / 1ps
// testbench for the periodic task scheduler: commands checked against a slot-table predictor
module tb_periodic_task_scheduler;
    import ptsch_pkg::*;

    localparam int SLOTS = TASK_SLOTS_DEF;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 345;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic done;
    rsp_t rsp;

    cmd_t cmd_backlog[$];
    rsp_t rsp_expected[$];
    rsp_t want_rsp;
    int phase_idle[4] = '{0, 54, 0, 20};
    int idle_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    logic task_used[SLOTS];
    logic task_ready[SLOTS];
    logic [15:0] task_period[SLOTS];
    logic [15:0] task_count[SLOTS];
    int scan_next;

    periodic_task_scheduler #(
        .TASK_SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .rsp(rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic rsp_t scheduler_outcome(cmd_t c);
        rsp_t r;
        logic [15:0] nxt;
        int pos;
        bit in_range;
        r = '0;
        in_range = c.task_index < SLOTS;
        case (c.opcode)
            OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (task_used[i])
                    begin
                        nxt = task_count[i] + 16'd1;
                        if (nxt >= task_period[i])
                        begin
                            nxt = '0;
                            task_ready[i] = 1'b1;
                        end
                        task_count[i] = nxt;
                    end
                end
            end
            OP_CREATE:
            begin
                if (in_range)
                begin
                    if (task_used[c.task_index])
                        r.create_rejected = 1'b1;
                    else
                    begin
                        task_used[c.task_index] = 1'b1;
                        task_ready[c.task_index] = 1'b0;
                        task_period[c.task_index] = c.period_ticks;
                        task_count[c.task_index] = '0;
                    end
                end
            end
            OP_WAKE:
            begin
                if (in_range)
                    task_ready[c.task_index] = 1'b1;
            end
            OP_SLEEP:
            begin
                if (in_range)
                    task_ready[c.task_index] = 1'b0;
            end
            OP_DISPATCH:
            begin
                for (int n = 0; n < SLOTS; n++)
                begin
                    pos = (scan_next + n) % SLOTS;
                    if (!r.served_valid && task_used[pos] && task_ready[pos])
                    begin
                        task_ready[pos] = 1'b0;
                        r.served_valid = 1'b1;
                        r.served_index = 4'(pos);
                        scan_next = (pos + 1) % SLOTS;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic queue_cmd(logic [2:0] op, int idx, int per);
        cmd_t c;
        c.opcode = op;
        c.task_index = 4'(idx);
        c.period_ticks = 16'(per);
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || start || rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
                cmd_backlog.delete(0);
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                cmd <= cmd_backlog[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                rsp_expected.push_back(scheduler_outcome(cmd));
            if (done)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $error("response with no command outstanding: %p", rsp);
                    fail_count++;
                end
                else
                begin
                    want_rsp = rsp_expected.pop_front();
                    if (rsp.served_valid !== want_rsp.served_valid)
                    begin
                        $error("served_valid: expected %0d, got %0d",
                               want_rsp.served_valid, rsp.served_valid);
                        fail_count++;
                    end
                    if (rsp.served_index !== want_rsp.served_index)
                    begin
                        $error("served_index: expected %0d, got %0d",
                               want_rsp.served_index, rsp.served_index);
                        fail_count++;
                    end
                    if (rsp.create_rejected !== want_rsp.create_rejected)
                    begin
                        $error("create_rejected: expected %0d, got %0d",
                               want_rsp.create_rejected, rsp.create_rejected);
                        fail_count++;
                    end
                end
            end
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int pick;
        logic [2:0] op;
        int idx;
        int per;

        for (int i = 0; i < SLOTS; i++)
        begin
            task_used[i] = 1'b0;
            task_ready[i] = 1'b0;
            task_period[i] = '0;
            task_count[i] = '0;
        end
        scan_next = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, zero and full periods, rejection, unused ready slot, wrap-around
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_CREATE, 0, 0);
        queue_cmd(OP_CREATE, 15, 65535);
        queue_cmd(OP_CREATE, 0, 7);
        queue_cmd(OP_CREATE, 5, 1);
        queue_cmd(OP_CREATE, 3, 2);
        queue_cmd(OP_WAKE, 7, 0);
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_TICK, 0, 0);
        queue_cmd(OP_TICK, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_TICK, 15, 65535);
        queue_cmd(OP_SLEEP, 5, 0);
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_WAKE, 15, 0);
        queue_cmd(OP_DISPATCH, 0, 0);
        queue_cmd(OP_SPARE_FIRST, 15, 65535);
        queue_cmd(OP_SPARE_MID, 10, 21845);
        queue_cmd(OP_SPARE_LAST, 5, 43690);
        queue_cmd(OP_SLEEP, 15, 0);
        queue_cmd(OP_DISPATCH, 0, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            idle_pct = phase_idle[ph];
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                idx = $urandom_range(SLOTS - 1);
                per = $urandom_range(65535);
                if (pick < 25)
                    op = OP_TICK;
                else if (pick < 33)
                begin
                    op = OP_CREATE;
                    if ($urandom_range(3) != 0)
                        per = $urandom_range(5);
                end
                else if (pick < 45)
                    op = OP_WAKE;
                else if (pick < 55)
                    op = OP_SLEEP;
                else if (pick < 95)
                    op = OP_DISPATCH;
                else
                    op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
                queue_cmd(op, idx, per);
            end
        end

        wait_drained();
        repeat (2 * SLOTS) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
